// File: hw/rtl/sosw_pkg.sv
package sosw_pkg;

	// Wave set
	localparam int NUM_WAVES = 3;

	// Sine table geometry (power of two depth)
	localparam int SINE_DEPTH = 1024;
	localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
	localparam int QUART_W    = SINE_IDX_W - 2;
	localparam int QUARTER    = SINE_DEPTH / 4;

	// Fixed-point constants for the table builder
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

	typedef logic [31:0]            phase_t;
	typedef logic [SINE_IDX_W-1:0]  sine_idx_t;
	typedef logic [QUART_W-1:0]     quart_idx_t;
	typedef logic [14:0]            sine_mag_t;
	typedef logic signed [15:0]     sine_t;
	typedef logic signed [31:0]     prod_t;
	typedef logic signed [15:0]     level_t;
	typedef sine_mag_t              qtab_t [QUARTER];

	// Per-wave phase increments in turns * 2^32, amplitude in Q16
	localparam phase_t WAVE_KX [NUM_WAVES] = '{32'd3611402020, 32'd3337975910, 32'd68356528};
	localparam phase_t WAVE_KY [NUM_WAVES] = '{32'd0, 32'd956991386, 32'd34178264};
	localparam phase_t WAVE_KT [NUM_WAVES] = '{32'd34178264, 32'd88863486, 32'd17089132};
	localparam logic signed [15:0] WAVE_AMP [NUM_WAVES] = '{16'sd19661, 16'sd16384, 16'sd16384};

	// First-quadrant sine of point j (0..QUARTER), Q30 Taylor series, rounded to Q1.14
	function automatic sine_mag_t quarter_sine(input int unsigned j);
		logic [63:0] r;
		logic [63:0] th;
		logic [63:0] th2;
		logic [63:0] t;
		logic [63:0] d;
		logic [63:0] s;
		int k;
		r   = 64'(j) << (32 - SINE_IDX_W);
		th  = (r * HALF_PI_Q30) >> 30;
		th2 = (th * th) >> 30;
		t   = Q30_ONE;
		for (k = 0; k < 5; k++) begin
			d = ((th2 * t) >> 30) / TAYLOR_DIV[k];
			t = (d > Q30_ONE) ? 64'd0 : Q30_ONE - d;
		end
		s = (th * t) >> 30;
		s = (s + 64'd32768) >> 16;
		if (s > 64'd16384) s = 64'd16384;
		return sine_mag_t'(s);
	endfunction

	function automatic qtab_t build_qtab();
		qtab_t tab;
		int unsigned j;
		for (j = 0; j < QUARTER; j++) begin
			tab[j] = quarter_sine(j);
		end
		return tab;
	endfunction

	// Quarter-wave table plus the peak point, which only the folded quadrants reach
	localparam qtab_t     SINE_QTAB = build_qtab();
	localparam sine_mag_t SINE_TOP  = quarter_sine(QUARTER);

endpackage

// File: hw/rtl/sum_of_sines_wave_height.sv
// Sum-of-sines water height. Each start beat carries one grid vertex (grid_x, grid_y)
// and a frame count time_step; at the pipeline's end done pulses for one cycle with
// height = water_level + three fixed sine waves, signed Q8.8, saturated. busy is
// always low: the six-stage pipeline takes a vertex every cycle and results leave in
// the order the vertices came in; the receiver cannot stall and must take each beat.
// The stages, in order, are: phase products, phase sum, sine table look-up,
// amplitude multiply, wave sum, round plus level and clamp. water_level is written
// through water_level_we and should only change while no vertex is in flight.
module sum_of_sines_wave_height
	import sosw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [7:0]   grid_x,
	input  logic [7:0]   grid_y,
	input  logic [23:0]  time_step,
	input  logic         water_level_we,
	input  logic [15:0]  water_level,
	output logic         done,
	output logic [15:0]  height
);

	level_t level_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	phase_t    px_s1   [NUM_WAVES];
	phase_t    py_s1   [NUM_WAVES];
	phase_t    pt_s1   [NUM_WAVES];
	sine_idx_t idx_s2  [NUM_WAVES];
	sine_t     sine_s3 [NUM_WAVES];
	prod_t     prod_s4 [NUM_WAVES];
	prod_t     sum_s5;
	logic [15:0] height_s6;

	// never stalls
	assign busy = 1'b0;

	// Level register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (water_level_we) begin
			level_q <= level_t'(water_level);
		end
	end

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: phase terms, mod one turn
	always_ff @(posedge clk) begin
		for (int w = 0; w < NUM_WAVES; w++) begin
			px_s1[w] <= phase_t'(32'(grid_x) * WAVE_KX[w]);
			py_s1[w] <= phase_t'(32'(grid_y) * WAVE_KY[w]);
			pt_s1[w] <= phase_t'(32'(time_step) * WAVE_KT[w]);
		end
	end

	// Stage 2: phase sum, keep the table index bits
	always_ff @(posedge clk) begin
		for (int w = 0; w < NUM_WAVES; w++) begin
			idx_s2[w] <= sine_idx_t'((px_s1[w] + py_s1[w] + pt_s1[w]) >> (32 - SINE_IDX_W));
		end
	end

	// Stage 3: quarter-wave table look-up with quadrant folding
	always_ff @(posedge clk) begin
		for (int w = 0; w < NUM_WAVES; w++) begin
			logic [1:0]  quad;
			quart_idx_t  low;
			sine_mag_t   mag;
			quad = idx_s2[w][SINE_IDX_W-1 -: 2];
			low  = idx_s2[w][QUART_W-1:0];
			if (quad[0] && low == '0) begin
				mag = SINE_TOP;
			end else if (quad[0]) begin
				mag = SINE_QTAB[quart_idx_t'(-low)];
			end else begin
				mag = SINE_QTAB[low];
			end
			sine_s3[w] <= quad[1] ? -sine_t'({1'b0, mag}) : sine_t'({1'b0, mag});
		end
	end

	// Stage 4: amplitude scale, Q16 x Q1.14
	always_ff @(posedge clk) begin
		for (int w = 0; w < NUM_WAVES; w++) begin
			prod_s4[w] <= WAVE_AMP[w] * sine_s3[w];
		end
	end

	// Stage 5: wave sum, fits 31 bits signed
	always_ff @(posedge clk) begin
		sum_s5 <= prod_s4[0] + prod_s4[1] + prod_s4[2];
	end

	// Stage 6: round to Q8.8, add level, clamp
	always_ff @(posedge clk) begin
		prod_t                rnd;
		logic signed [9:0]    waves;
		logic signed [16:0]   h;
		rnd   = sum_s5 + prod_t'(32'sd1 <<< 21);
		waves = rnd[31:22];
		h     = {level_q[15], level_q} + {{7{waves[9]}}, waves};
		if (h[16] != h[15]) begin
			height_s6 <= h[16] ? 16'h8000 : 16'h7FFF;
		end else begin
			height_s6 <= h[15:0];
		end
	end

	assign done   = v_s6;
	assign height = height_s6;

	// A result only follows an earlier vertex start
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 6))
		else $error("done without a matching start");

	// Table stage never exceeds one in Q1.14
	a_sine_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (sine_s3[0] <= 16'sd16384 && sine_s3[0] >= -16'sd16384 &&
		          sine_s3[1] <= 16'sd16384 && sine_s3[1] >= -16'sd16384 &&
		          sine_s3[2] <= 16'sd16384 && sine_s3[2] >= -16'sd16384))
		else $error("sine value out of range");

	// With a zero level the waves alone bound the height
	a_wave_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(level_q) == 16'sd0) |->
		($signed(height) <= 16'sd205 && $signed(height) >= -16'sd205))
		else $error("wave sum outside its bound");

endmodule
